FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the piecewise-linear table RTL.
// Each macro takes a label, clock, active-low reset, condition(s) and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pwlt_pkg.sv
// Package for the piecewise-linear table: codes, widths and the command and
// status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package pwlt_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntW  = 5;

  localparam logic signed [DataW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;

  // Operation selected by the mode field of an input beat.
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_VALUE  = 2'd2,
    MODE_RANGE  = 2'd3
  } mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_e;

  // One table entry.
  typedef struct packed {
    logic signed [DataW-1:0] x0;
    logic signed [DataW-1:0] x1;
    logic signed [DataW-1:0] v0;
    logic signed [DataW-1:0] v1;
  } seg_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic scan;
    logic prep;
    logic mul;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    mode_e mode;
    logic  scan_done;
    logic  hit;
    logic  dx_pos;
    logic  out_free;
  } sts_t;

endpackage

FILE: rtl/core/pwlt_ctrl.sv
// Controller state machine of the piecewise-linear table.
// Depends on pwlt_pkg and assert_macros.svh; drives pwlt_dpath by commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pwlt_ctrl import pwlt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [DivCntW-1:0]   div_cnt_q;
  mode_e                in_mode;

  assign in_mode    = mode_e'(mode_i);
  assign in_ready_o = (state_q == S_IDLE);

  // Commands follow from the current state and the datapath status.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: cmd_o.capture  = in_valid_i;
      S_SCAN: cmd_o.scan     = !sts_i.scan_done;
      S_PREP: cmd_o.prep     = 1'b1;
      S_MUL:  cmd_o.mul      = 1'b1;
      S_DIV:  cmd_o.div_step = 1'b1;
      S_DONE: cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

  // State and division step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      div_cnt_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_mode == MODE_VALUE || in_mode == MODE_RANGE) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (sts_i.scan_done) begin
            if (sts_i.mode == MODE_VALUE && sts_i.hit) begin
              state_q <= S_PREP;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_PREP: begin
          state_q <= sts_i.dx_pos ? S_MUL : S_DONE;
        end
        S_MUL: begin
          state_q   <= S_DIV;
          div_cnt_q <= '0;
        end
        S_DIV: begin
          if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
            state_q   <= S_DONE;
            div_cnt_q <= '0;
          end else begin
            div_cnt_q <= div_cnt_q + 1'b1;
          end
        end
        S_DONE: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // An accepted beat always starts work.
  `ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && in_ready_o,
               state_q != S_IDLE, "accepted beat left the controller idle")
  // The step counter is back at zero whenever the controller is idle.
  `ASSERT_IMPLIES(a_idle_cnt_zero, clk_i, rst_ni, state_q == S_IDLE,
                  div_cnt_q == '0, "division counter not cleared when idle")
  // Multiplication is always followed by the division.
  `ASSERT_NEXT(a_mul_then_div, clk_i, rst_ni, state_q == S_MUL,
               state_q == S_DIV, "multiply not followed by divide")

endmodule

FILE: rtl/core/pwlt_dpath.sv
// Datapath of the piecewise-linear table: segment memory, scan compare,
// min/max, multiplier, bit-serial divider and output register. Uses pwlt_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pwlt_dpath import pwlt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic [1:0]              mode_i,
  input  logic signed [DataW-1:0] seg_start_x_i,
  input  logic signed [DataW-1:0] seg_end_x_i,
  input  logic signed [DataW-1:0] seg_start_value_i,
  input  logic signed [DataW-1:0] seg_end_value_i,
  input  logic signed [DataW-1:0] query_x_i,
  input  logic signed [DataW-1:0] default_value_i,
  input  logic signed [DataW-1:0] range_low_i,
  input  logic signed [DataW-1:0] range_high_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [DataW-1:0] interp_value_o,
  output logic signed [DataW-1:0] min_value_o,
  output logic signed [DataW-1:0] max_value_o,
  output logic [1:0]              status_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Latched operands of the current beat.
  mode_e                   op_mode_q;
  logic signed [DataW-1:0] qx_q, dflt_q, lo_q, hi_q;

  // Table state.
  seg_t                    mem [TABLE_DEPTH];
  seg_t                    rdata_q;
  logic [CntW-1:0]         cnt_q;
  logic                    full_q;

  // Scan state.
  logic [CntW-1:0]         idx_q;
  logic                    rvld_q;
  logic                    hit_q, any_q;
  logic signed [DataW-1:0] min_q, max_q;
  seg_t                    hseg_q;

  // Interpolation state.
  logic [DataW-1:0]        off_q, mag_q, dx_q;
  logic                    neg_q;
  logic [DataW-1:0]        rem_q, quo_q;

  // Output register.
  logic                    out_vld_q;
  logic signed [DataW-1:0] interp_q, min_out_q, max_out_q;
  logic [1:0]              status_q;

  logic                    mem_we, mem_re, table_full;
  logic                    match, overlap;
  logic signed [DataW-1:0] seg_min, seg_max;
  logic [DataW:0]          div_trial, div_diff;
  logic                    div_ge;
  logic                    dv_neg;
  logic signed [DataW-1:0] interp_res;
  mode_e                   in_mode;

  assign in_mode    = mode_e'(mode_i);
  assign table_full = (cnt_q >= CntW'(TABLE_DEPTH));
  assign mem_we     = cmd_i.capture && in_mode == MODE_APPEND && !table_full;
  assign mem_re     = cmd_i.scan && (idx_q < cnt_q);

  // Segment memory: one write port at the fill count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[IdxW-1:0]] <= '{x0: seg_start_x_i, x1: seg_end_x_i,
                                v0: seg_start_value_i, v1: seg_end_value_i};
    end
    if (mem_re) begin
      rdata_q <= mem[idx_q[IdxW-1:0]];
    end
  end

  // Tests applied to the entry read in the previous cycle.
  assign match   = (rdata_q.x0 <= qx_q) && (qx_q <= rdata_q.x1);
  assign overlap = (hi_q >= rdata_q.x0) && (lo_q <= rdata_q.x1);
  assign seg_min = (rdata_q.v0 < rdata_q.v1) ? rdata_q.v0 : rdata_q.v1;
  assign seg_max = (rdata_q.v0 > rdata_q.v1) ? rdata_q.v0 : rdata_q.v1;

  // Fill count, scan control and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      full_q <= 1'b0;
      idx_q  <= '0;
      rvld_q <= 1'b0;
      hit_q  <= 1'b0;
      any_q  <= 1'b0;
    end else if (cmd_i.capture) begin
      idx_q  <= '0;
      rvld_q <= 1'b0;
      hit_q  <= 1'b0;
      any_q  <= 1'b0;
      full_q <= (in_mode == MODE_APPEND) && table_full;
      if (in_mode == MODE_CLEAR) begin
        cnt_q <= '0;
      end else if (mem_we) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else if (cmd_i.scan) begin
      rvld_q <= mem_re;
      if (mem_re) begin
        idx_q <= idx_q + 1'b1;
      end
      if (rvld_q && op_mode_q == MODE_VALUE && match) begin
        hit_q <= 1'b1;
      end
      if (rvld_q && op_mode_q == MODE_RANGE && overlap) begin
        any_q <= 1'b1;
      end
    end
  end

  // Operand capture, first hit and running min/max.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_mode_q <= in_mode;
      qx_q      <= query_x_i;
      dflt_q    <= default_value_i;
      lo_q      <= range_low_i;
      hi_q      <= range_high_i;
      min_q     <= QMax;
      max_q     <= QMin;
    end else if (cmd_i.scan && rvld_q) begin
      if (op_mode_q == MODE_VALUE && match && !hit_q) begin
        hseg_q <= rdata_q;
      end
      if (op_mode_q == MODE_RANGE && overlap) begin
        if (seg_min < min_q) begin
          min_q <= seg_min;
        end
        if (seg_max > max_q) begin
          max_q <= seg_max;
        end
      end
    end
  end

  // Slope operand: the value step falls when the end value is below the start.
  assign dv_neg = (hseg_q.v1 < hseg_q.v0);

  // Restoring divider, one quotient bit per step.
  assign div_trial = {rem_q, quo_q[DataW-1]};
  assign div_diff  = div_trial - {1'b0, dx_q};
  assign div_ge    = (div_trial >= {1'b0, dx_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      off_q <= qx_q - hseg_q.x0;
      dx_q  <= hseg_q.x1 - hseg_q.x0;
      neg_q <= dv_neg;
      mag_q <= dv_neg ? (hseg_q.v0 - hseg_q.v1) : (hseg_q.v1 - hseg_q.v0);
    end
    if (cmd_i.mul) begin
      {rem_q, quo_q} <= off_q * mag_q;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_diff[DataW-1:0] : div_trial[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], div_ge};
    end
  end

  // Forward-span hit: start value stepped toward end value by truncated quotient.
  always_comb begin
    if (!hit_q) begin
      interp_res = dflt_q;
    end else if (hseg_q.x1 > hseg_q.x0) begin
      interp_res = neg_q ? (hseg_q.v0 - $signed(quo_q)) : (hseg_q.v0 + $signed(quo_q));
    end else begin
      interp_res = hseg_q.v0;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      interp_q  <= '0;
      min_out_q <= '0;
      max_out_q <= '0;
      status_q  <= STATUS_OK;
      unique case (op_mode_q)
        MODE_CLEAR: ;
        MODE_APPEND: status_q <= full_q ? STATUS_FULL : STATUS_OK;
        MODE_VALUE: begin
          interp_q <= interp_res;
          status_q <= hit_q ? STATUS_OK : STATUS_MISS;
        end
        MODE_RANGE: begin
          min_out_q <= min_q;
          max_out_q <= max_q;
          status_q  <= any_q ? STATUS_OK : STATUS_MISS;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_vld_q;
  assign interp_value_o = interp_q;
  assign min_value_o    = min_out_q;
  assign max_value_o    = max_out_q;
  assign status_o       = status_q;

  // Status toward the controller.
  assign sts_o.mode      = op_mode_q;
  assign sts_o.scan_done = hit_q || (!rvld_q && idx_q >= cnt_q);
  assign sts_o.hit       = hit_q;
  assign sts_o.dx_pos    = (hseg_q.x1 > hseg_q.x0);
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  // The fill count never passes the table depth.
  `ASSERT_IMPLIES(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(TABLE_DEPTH),
                  "segment count beyond table depth")
  // The partial remainder stays below the divisor, so the quotient fits.
  `ASSERT_IMPLIES(a_rem_bound, clk_i, rst_ni, cmd_i.div_step, rem_q < dx_q,
                  "divider remainder not below divisor")
  // A new result is loaded only when the previous beat is gone.
  `ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, cmd_i.load_out,
                  !out_vld_q || out_ready_i, "result overwritten before taken")

endmodule

FILE: rtl/core/piecewise_linear_table.sv
// Piecewise-linear table, top level. Clear and append beats go straight to the
// result; range queries and value misses scan all stored segments, while a value
// hit stops the scan at the first matching entry and, for a forward span, then
// interpolates with a multiply followed by a 32-step bit-serial divide. One item
// at a time; the next beat can be taken in the cycle after the result is loaded.
// Reset clears the state, count, flags and output valid. Uses pwlt_ctrl, pwlt_dpath.
`timescale 1ns / 1ps

module piecewise_linear_table import pwlt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              mode_i,
  input  logic signed [DataW-1:0] seg_start_x_i,
  input  logic signed [DataW-1:0] seg_end_x_i,
  input  logic signed [DataW-1:0] seg_start_value_i,
  input  logic signed [DataW-1:0] seg_end_value_i,
  input  logic signed [DataW-1:0] query_x_i,
  input  logic signed [DataW-1:0] default_value_i,
  input  logic signed [DataW-1:0] range_low_i,
  input  logic signed [DataW-1:0] range_high_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] interp_value_o,
  output logic signed [DataW-1:0] min_value_o,
  output logic signed [DataW-1:0] max_value_o,
  output logic [1:0]              status_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  pwlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, arithmetic and output register.
  pwlt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mode_i            (mode_i),
    .seg_start_x_i     (seg_start_x_i),
    .seg_end_x_i       (seg_end_x_i),
    .seg_start_value_i (seg_start_value_i),
    .seg_end_value_i   (seg_end_value_i),
    .query_x_i         (query_x_i),
    .default_value_i   (default_value_i),
    .range_low_i       (range_low_i),
    .range_high_i      (range_high_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .interp_value_o    (interp_value_o),
    .min_value_o       (min_value_o),
    .max_value_o       (max_value_o),
    .status_o          (status_o)
  );

endmodule

FILE: tb/piecewise_linear_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_table: clear, append and query beats
// with random idling on both sides, checked against a scoreboard model of the table.
// Depends on pwlt_pkg and the piecewise_linear_table RTL.

module piecewise_linear_table_tb;
  import pwlt_pkg::*;

  localparam int unsigned TableDepth   = 16;
  localparam int unsigned RandomItems  = 700;
  localparam int unsigned DrainCycles  = 80;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned HoldAtItem   = 300;
  localparam int unsigned MaxReports   = 10;

  // One input beat and one result beat as the testbench sees them.
  typedef struct {
    mode_e                   mode;
    logic signed [DataW-1:0] seg_x0, seg_x1, seg_v0, seg_v1;
    logic signed [DataW-1:0] query_x, dflt, win_lo, win_hi;
  } pwl_cmd_t;

  typedef struct {
    logic signed [DataW-1:0] interp;
    logic signed [DataW-1:0] min_v;
    logic signed [DataW-1:0] max_v;
    logic [1:0]              status;
  } pwl_res_t;

  // Shadow copy of the segment table plus the queue of results still owed by the block.
  class pwl_scoreboard;
    logic signed [DataW-1:0] x0_tbl[TableDepth];
    logic signed [DataW-1:0] x1_tbl[TableDepth];
    logic signed [DataW-1:0] v0_tbl[TableDepth];
    logic signed [DataW-1:0] v1_tbl[TableDepth];
    int unsigned             seg_count;
    pwl_res_t                expected_q[$];
    int unsigned             failures;

    // Applies an accepted command to the shadow table and queues its result.
    function void note_command(pwl_cmd_t c);
      pwl_res_t           r;
      logic signed [63:0] x, lo, hi, s0, s1, w0, w1, dx, dv;
      logic [63:0]        mag, off, quo;
      bit                 found;
      r.interp = '0;
      r.min_v  = '0;
      r.max_v  = '0;
      r.status = STATUS_OK;
      found    = 1'b0;
      case (c.mode)
        MODE_CLEAR: begin
          seg_count = 0;
        end
        MODE_APPEND: begin
          if (seg_count >= TableDepth) begin
            r.status = STATUS_FULL;
          end else begin
            x0_tbl[seg_count] = c.seg_x0;
            x1_tbl[seg_count] = c.seg_x1;
            v0_tbl[seg_count] = c.seg_v0;
            v1_tbl[seg_count] = c.seg_v1;
            seg_count++;
          end
        end
        MODE_VALUE: begin
          // The first segment in append order whose closed span holds x wins.
          x = c.query_x;
          for (int i = 0; i < seg_count && !found; i++) begin
            s0 = x0_tbl[i];
            s1 = x1_tbl[i];
            if (s0 <= x && x <= s1) begin
              found = 1'b1;
              dx = s1 - s0;
              w0 = v0_tbl[i];
              w1 = v1_tbl[i];
              if (dx <= 0) begin
                r.interp = v0_tbl[i];
              end else begin
                // Magnitude times offset fits in 64 bits; truncation pulls toward the start.
                dv  = w1 - w0;
                mag = (dv < 0) ? -dv : dv;
                off = x - s0;
                quo = (mag * off) / dx;
                r.interp = (dv < 0) ? w0 - quo : w0 + quo;
              end
            end
          end
          if (!found) begin
            r.interp = c.dflt;
            r.status = STATUS_MISS;
          end
        end
        default: begin
          // Range query: end values of every segment overlapping the window.
          lo = c.win_lo;
          hi = c.win_hi;
          r.min_v = QMax;
          r.max_v = QMin;
          for (int i = 0; i < seg_count; i++) begin
            s0 = x0_tbl[i];
            s1 = x1_tbl[i];
            if (hi >= s0 && lo <= s1) begin
              found = 1'b1;
              if (v0_tbl[i] < r.min_v) r.min_v = v0_tbl[i];
              if (v1_tbl[i] < r.min_v) r.min_v = v1_tbl[i];
              if (v0_tbl[i] > r.max_v) r.max_v = v0_tbl[i];
              if (v1_tbl[i] > r.max_v) r.max_v = v1_tbl[i];
            end
          end
          if (!found) r.status = STATUS_MISS;
        end
      endcase
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Compares a result beat with the oldest outstanding expectation.
    function void check_result(pwl_res_t a);
      pwl_res_t e;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("ERROR: result beat with nothing outstanding: interp=%h min=%h max=%h st=%0d",
                   a.interp, a.min_v, a.max_v, a.status);
        end
        return;
      end
      e = expected_q.pop_front();
      if (a.interp !== e.interp || a.min_v !== e.min_v || a.max_v !== e.max_v ||
          a.status !== e.status) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("ERROR: mismatch at %0t: interp exp %h got %h, min exp %h got %h,",
                   $realtime, e.interp, a.interp, e.min_v, a.min_v);
          $display("       max exp %h got %h, status exp %0d got %0d",
                   e.max_v, a.max_v, e.status, a.status);
        end
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              mode_i;
  logic signed [DataW-1:0] seg_start_x_i;
  logic signed [DataW-1:0] seg_end_x_i;
  logic signed [DataW-1:0] seg_start_value_i;
  logic signed [DataW-1:0] seg_end_value_i;
  logic signed [DataW-1:0] query_x_i;
  logic signed [DataW-1:0] default_value_i;
  logic signed [DataW-1:0] range_low_i;
  logic signed [DataW-1:0] range_high_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [DataW-1:0] interp_value_o;
  logic signed [DataW-1:0] min_value_o;
  logic signed [DataW-1:0] max_value_o;
  logic [1:0]              status_o;

  pwl_scoreboard sb = new();
  int unsigned   items_sent;
  int            tx_calm;
  int            rx_calm;
  logic          hold_off;

  piecewise_linear_table #(
    .TABLE_DEPTH (TableDepth)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .seg_start_x_i     (seg_start_x_i),
    .seg_end_x_i       (seg_end_x_i),
    .seg_start_value_i (seg_start_value_i),
    .seg_end_value_i   (seg_end_value_i),
    .query_x_i         (query_x_i),
    .default_value_i   (default_value_i),
    .range_low_i       (range_low_i),
    .range_high_i      (range_high_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .interp_value_o    (interp_value_o),
    .min_value_o       (min_value_o),
    .max_value_o       (max_value_o),
    .status_o          (status_o)
  );

  // 100 MHz clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Idle cycles before a beat; now and then a calm stretch with no idling at all.
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 30);
    return $urandom_range(0, 14);
  endfunction

  // A Q16.16 coordinate or value: mostly a moderate band so segments overlap.
  function automatic logic signed [DataW-1:0] pick_q16();
    case ($urandom_range(0, 7))
      0: begin
        return $urandom;
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       return QMin;
          1:       return QMax;
          2:       return '0;
          default: return -1;
        endcase
      end
      default: begin
        return ($signed($urandom_range(0, 4096)) - 2048) <<< 12;
      end
    endcase
  endfunction

  // Every field random, so fields the mode ignores toggle as well.
  function automatic pwl_cmd_t random_fields(mode_e m);
    pwl_cmd_t c;
    c.mode    = m;
    c.seg_x0  = $urandom;
    c.seg_x1  = $urandom;
    c.seg_v0  = $urandom;
    c.seg_v1  = $urandom;
    c.query_x = $urandom;
    c.dflt    = $urandom;
    c.win_lo  = $urandom;
    c.win_hi  = $urandom;
    return c;
  endfunction

  // Presents one beat after a random gap and holds it until the block takes it.
  task automatic send_item(pwl_cmd_t c);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    mode_i            <= c.mode;
    seg_start_x_i     <= c.seg_x0;
    seg_end_x_i       <= c.seg_x1;
    seg_start_value_i <= c.seg_v0;
    seg_end_value_i   <= c.seg_v1;
    query_x_i         <= c.query_x;
    default_value_i   <= c.dflt;
    range_low_i       <= c.win_lo;
    range_high_i      <= c.win_hi;
    in_valid_i        <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_command(c);
    items_sent++;
  endtask

  task automatic send_clear();
    send_item(random_fields(MODE_CLEAR));
  endtask

  task automatic send_append(logic signed [DataW-1:0] x0, logic signed [DataW-1:0] x1,
                             logic signed [DataW-1:0] v0, logic signed [DataW-1:0] v1);
    pwl_cmd_t c;
    c = random_fields(MODE_APPEND);
    c.seg_x0 = x0;
    c.seg_x1 = x1;
    c.seg_v0 = v0;
    c.seg_v1 = v1;
    send_item(c);
  endtask

  task automatic send_value(logic signed [DataW-1:0] x, logic signed [DataW-1:0] dflt);
    pwl_cmd_t c;
    c = random_fields(MODE_VALUE);
    c.query_x = x;
    c.dflt    = dflt;
    send_item(c);
  endtask

  task automatic send_range(logic signed [DataW-1:0] lo, logic signed [DataW-1:0] hi);
    pwl_cmd_t c;
    c = random_fields(MODE_RANGE);
    c.win_lo = lo;
    c.win_hi = hi;
    send_item(c);
  endtask

  // Mostly forward spans, with zero-width and arbitrary (often reversed) ones mixed in.
  task automatic append_random();
    logic signed [DataW-1:0] x0, x1;
    logic signed [63:0]      end64, span;
    x0 = pick_q16();
    case ($urandom_range(0, 9))
      0: begin
        x1 = x0;
      end
      1, 2: begin
        x1 = pick_q16();
      end
      default: begin
        span  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
        end64 = x0;
        end64 = end64 + span;
        x1    = (end64 > QMax) ? QMax : end64[DataW-1:0];
      end
    endcase
    send_append(x0, x1, pick_q16(), pick_q16());
  endtask

  // Value query aimed inside a stored span most of the time.
  task automatic value_random();
    logic signed [DataW-1:0] x;
    logic signed [63:0]      a, b, pos;
    int                      k;
    x = pick_q16();
    if (sb.seg_count > 0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, sb.seg_count - 1);
      a = sb.x0_tbl[k];
      b = sb.x1_tbl[k];
      if (a <= b) begin
        case ($urandom_range(0, 3))
          0:       pos = a;
          1:       pos = b;
          default: pos = a + ((b - a) * $urandom_range(0, 1000)) / 1000;
        endcase
        x = pos[DataW-1:0];
      end else begin
        x = sb.x0_tbl[k];
      end
    end
    send_value(x, $urandom);
  endtask

  // Range window: around a stored segment, touching one end, or random.
  task automatic range_random();
    logic signed [DataW-1:0] lo, hi, t;
    int                      k;
    lo = pick_q16();
    hi = pick_q16();
    if (sb.seg_count > 0 && $urandom_range(0, 2) != 0) begin
      k = $urandom_range(0, sb.seg_count - 1);
      case ($urandom_range(0, 3))
        0: begin
          lo = sb.x0_tbl[k];
          hi = sb.x1_tbl[k];
        end
        1: begin
          lo = sb.x1_tbl[k];
          hi = sb.x1_tbl[k];
        end
        2: begin
          lo = sb.x0_tbl[k];
          hi = sb.x0_tbl[k];
        end
        default: begin
          hi = sb.x0_tbl[k];
        end
      endcase
    end else if ($urandom_range(0, 3) != 0 && lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    send_range(lo, hi);
  endtask

  // Directed corners: empty table, extreme spans, zero-width, reversed, full table.
  task automatic run_directed();
    send_value('0, QMin);
    send_range(QMin, QMax);
    send_append(QMin, QMax, QMin, QMax);
    send_value(QMax, '0);
    send_value(QMin, '0);
    send_value(32'sh0000_8000, '0);
    send_clear();
    send_append(32'sh0005_0000, 32'sh0005_0000, 32'sd100, -32'sd7);
    send_append(32'sh000A_0000, -32'sh000A_0000, QMax, QMin);
    send_value(32'sh0005_0000, 32'sd1);
    send_value('0, QMax);
    send_range(-32'sh0014_0000, 32'sh0014_0000);
    send_range(32'sh0014_0000, -32'sh0014_0000);
    send_append('0, 32'sh0001_0000, QMax, QMin);
    send_value(32'sh0000_8000, '0);
    // Thirteen more appends fill the table; the last one must be refused.
    for (int i = 0; i < 14; i++) append_random();
  endtask

  // Random programs: build a table, then query it; a tenth of them are pure noise.
  task automatic run_random();
    int unsigned start;
    int          n;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(random_fields(mode_e'($urandom_range(0, 3))));
      end else begin
        if ($urandom_range(0, 3) != 0) send_clear();
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 6);
        repeat (n) append_random();
        n = $urandom_range(2, 8);
        repeat (n) begin
          case ($urandom_range(0, 7))
            0:       append_random();
            1, 2, 3: range_random();
            default: value_random();
          endcase
        end
      end
    end
  endtask

  // Result side: random ready gaps, long hold-off on request, check every beat.
  initial begin
    int       gap;
    pwl_res_t got;
    out_ready_i = 1'b0;
    gap = 0;
    wait (rst_ni === 1'b1);
    gap = draw_gap(rx_calm);
    forever begin
      @(negedge clk_i);
      out_ready_i <= (gap == 0) && !hold_off;
      if (gap > 0) gap--;
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        got.interp = interp_value_o;
        got.min_v  = min_value_o;
        got.max_v  = max_value_o;
        got.status = status_o;
        sb.check_result(got);
        gap = draw_gap(rx_calm);
      end
    end
  end

  // Back-pressure: the receiver stalls for a long stretch while the sender waits.
  initial begin
    hold_off = 1'b0;
    wait (items_sent >= HoldAtItem);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Main sequence: reset, stimulus, drain, verdict.
  initial begin
    items_sent        = 0;
    tx_calm           = 0;
    rx_calm           = 0;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    mode_i            = MODE_CLEAR;
    seg_start_x_i     = '0;
    seg_end_x_i       = '0;
    seg_start_value_i = '0;
    seg_end_value_i   = '0;
    query_x_i         = '0;
    default_value_i   = '0;
    range_low_i       = '0;
    range_high_i      = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    run_random();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("piecewise_linear_table_tb: PASS");
    end else begin
      $display("piecewise_linear_table_tb: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("piecewise_linear_table_tb: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/pwlt_pkg.sv
rtl/core/pwlt_ctrl.sv
rtl/core/pwlt_dpath.sv
rtl/core/piecewise_linear_table.sv
tb/piecewise_linear_table_tb.sv
